FILE: hdl/ssnd_pkg.sv
// Shared types and constants for the seven-segment frame sender.
// Used by ssnd_encode and seven_segment_number_display_sender; no dependencies.
`default_nettype none

package ssnd_pkg;

	localparam logic [1:0] ACT_SHOW  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_INIT  = 2'd2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [7:0] CMD_DATA       = 8'h40;
	localparam logic [7:0] CMD_ADDR       = 8'hC0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
	localparam logic [7:0] SEG_DOT        = 8'h80;
	localparam logic [7:0] SEG_ZERO       = 8'h3f;

	localparam logic [15:0] MAX_SHOW = 16'd9999;
	localparam logic [2:0]  BRIGHT_RESET = 3'd3;

	// floor(n / d) = (n * RECIP) >> SHIFT, exact for n <= 9999
	localparam logic [13:0] RECIP_1000 = 14'd8389;
	localparam logic [13:0] RECIP_100  = 14'd5243;
	localparam logic [13:0] RECIP_10   = 14'd6554;

	typedef struct packed {
		logic             is_init;
		logic [2:0]       bright;
		logic [3:0][7:0]  seg;      // seg[0] is the leftmost digit
	} frame_set_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ssnd_encode.sv
// Three-stage pipeline turning one action into the segment bytes of a frame set.
// Depends on ssnd_pkg for action codes, reciprocal constants and the segment table.
`default_nettype none

module ssnd_encode import ssnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] number,
	input  logic [3:0]  point_mask,
	input  logic [2:0]  bright,
	output logic        set_valid,
	input  logic        set_ready,
	output frame_set_t  set_data
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        adv1, adv2, adv3;

	logic [1:0]  action_s1;
	logic [15:0] number_s1;
	logic [3:0]  dots_s1;
	logic [2:0]  bright_s1;
	logic        keep_s1;

	logic        is_init_s2, blank_s2;
	logic [13:0] n_s2;
	logic [3:0]  q1000_s2;
	logic [6:0]  q100_s2;
	logic [9:0]  q10_s2;
	logic [3:0]  dots_s2;
	logic [2:0]  bright_s2;

	frame_set_t  set_s3;

	logic [27:0] prod_1000, prod_100, prod_10;
	logic [6:0]  rem_100;
	logic [9:0]  rem_10;
	logic [13:0] rem_1;
	logic        lt1000, lt100, lt10, restore;
	logic [3:0][7:0] seg;

	assign adv3     = !valid_s3 || set_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		case (action_s1)
			ACT_SHOW:  keep_s1 = (number_s1 <= MAX_SHOW);
			ACT_CLEAR: keep_s1 = 1'b1;
			ACT_INIT:  keep_s1 = 1'b1;
			default:   keep_s1 = 1'b0;
		endcase
	end

	assign prod_1000 = {14'd0, number_s1[13:0]} * {14'd0, RECIP_1000};
	assign prod_100  = {14'd0, number_s1[13:0]} * {14'd0, RECIP_100};
	assign prod_10   = {14'd0, number_s1[13:0]} * {14'd0, RECIP_10};

	assign rem_100 = q100_s2 - {q1000_s2, 3'b000} - {2'b00, q1000_s2, 1'b0};
	assign rem_10  = q10_s2 - {q100_s2, 3'b000} - {2'b00, q100_s2, 1'b0};
	assign rem_1   = n_s2 - {1'b0, q10_s2, 3'b000} - {3'b000, q10_s2, 1'b0};

	assign lt1000  = (n_s2 < 14'd1000);
	assign lt100   = (n_s2 < 14'd100);
	assign lt10    = (n_s2 < 14'd10);
	assign restore = (dots_s2[3] && lt1000) || (dots_s2[2] && lt100) ||
	                 (dots_s2[1] && lt10);

	always_comb begin
		seg[0] = seg_code(q1000_s2);
		seg[1] = seg_code(rem_100[3:0]);
		seg[2] = seg_code(rem_10[3:0]);
		seg[3] = seg_code(rem_1[3:0]);
		if (lt1000) begin
			seg[0] = (restore && !lt100) ? SEG_ZERO : 8'h00;
		end
		if (lt100) begin
			seg[1] = (restore && !lt10) ? SEG_ZERO : 8'h00;
		end
		if (lt10) begin
			seg[2] = restore ? SEG_ZERO : 8'h00;
		end
		for (int i = 0; i < 4; i++) begin
			if (dots_s2[3 - i]) begin
				seg[i] = seg[i] | SEG_DOT;
			end
			if (blank_s2 || is_init_s2) begin
				seg[i] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1 && keep_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			action_s1 <= action;
			number_s1 <= number;
			dots_s1   <= point_mask;
			bright_s1 <= bright;
		end
		if (adv2 && valid_s1) begin
			is_init_s2 <= (action_s1 == ACT_INIT);
			blank_s2   <= (action_s1 == ACT_CLEAR);
			n_s2       <= number_s1[13:0];
			q1000_s2   <= prod_1000[26:23];
			q100_s2    <= prod_100[25:19];
			q10_s2     <= prod_10[25:16];
			dots_s2    <= dots_s1;
			bright_s2  <= bright_s1;
		end
		if (adv3 && valid_s2) begin
			set_s3.is_init <= is_init_s2;
			set_s3.bright  <= bright_s2;
			set_s3.seg     <= seg;
		end
	end

	assign set_valid = valid_s3;
	assign set_data  = set_s3;

endmodule

`default_nettype wire

FILE: hdl/seven_segment_number_display_sender.sv
// Top level of the seven-segment frame sender: brightness register, frame sequencer
// and output register. Depends on ssnd_pkg and ssnd_encode.
`default_nettype none

// An input transfer can be taken on every clock while the encoder is not stalled. Each
// action passes a three-stage encoder (input register, constant-reciprocal digit split,
// segment lookup), and its first frame is then loaded into the output register. The
// frame sequencer then emits one frame per cycle while out_ready allows: ten for show
// and clear, three for init, none for a show above 9999 or an unused action code.
// Sustained throughput is therefore set by the sequencer; up to two further items
// queue in the encoder stages meanwhile.
// Brightness is written through the cfg channel, which is always ready.
module seven_segment_number_display_sender import ssnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] number,
	input  logic [3:0]  point_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  frame_kind,
	output logic [7:0]  byte_value,
	output logic        last
);

	localparam logic [3:0] FR_START_A = 4'd0;
	localparam logic [3:0] FR_CMD_A   = 4'd1;
	localparam logic [3:0] FR_STOP_A  = 4'd2;
	localparam logic [3:0] FR_START_B = 4'd3;
	localparam logic [3:0] FR_CMD_B   = 4'd4;
	localparam logic [3:0] FR_SEG0    = 4'd5;
	localparam logic [3:0] FR_SEG1    = 4'd6;
	localparam logic [3:0] FR_SEG2    = 4'd7;
	localparam logic [3:0] FR_SEG3    = 4'd8;
	localparam logic [3:0] FR_STOP_B  = 4'd9;

	logic [2:0]  brightness_q;
	logic [3:0]  idx_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        set_valid, set_ready, out_adv;
	frame_set_t  set_data;
	logic [1:0]  nxt_kind;
	logic [7:0]  nxt_byte;
	logic        nxt_last;

	ssnd_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.number     (number),
		.point_mask (point_mask),
		.bright     (brightness_q),
		.set_valid  (set_valid),
		.set_ready  (set_ready),
		.set_data   (set_data)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RESET;
		end else if (cfg_valid) begin
			brightness_q <= cfg_data;
		end
	end

	always_comb begin
		nxt_kind = KIND_DATA;
		nxt_byte = 8'h00;
		nxt_last = 1'b0;
		if (set_data.is_init) begin
			case (idx_q)
				FR_START_A: nxt_kind = KIND_START;
				FR_CMD_A:   nxt_byte = CMD_DISPLAY_ON | {5'd0, set_data.bright};
				FR_STOP_A: begin
					nxt_kind = KIND_STOP;
					nxt_last = 1'b1;
				end
				default: nxt_last = 1'b1;
			endcase
		end else begin
			case (idx_q)
				FR_START_A: nxt_kind = KIND_START;
				FR_CMD_A:   nxt_byte = CMD_DATA;
				FR_STOP_A:  nxt_kind = KIND_STOP;
				FR_START_B: nxt_kind = KIND_START;
				FR_CMD_B:   nxt_byte = CMD_ADDR;
				FR_SEG0:    nxt_byte = set_data.seg[0];
				FR_SEG1:    nxt_byte = set_data.seg[1];
				FR_SEG2:    nxt_byte = set_data.seg[2];
				FR_SEG3:    nxt_byte = set_data.seg[3];
				FR_STOP_B: begin
					nxt_kind = KIND_STOP;
					nxt_last = 1'b1;
				end
				default: nxt_last = 1'b1;
			endcase
		end
	end

	assign out_adv   = !out_valid_q || out_ready;
	assign set_ready = out_adv && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= FR_START_A;
		end else if (out_adv) begin
			out_valid_q <= set_valid;
			if (set_valid) begin
				idx_q <= nxt_last ? FR_START_A : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && set_valid) begin
			kind_q <= nxt_kind;
			byte_q <= nxt_byte;
			last_q <= nxt_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_kind = kind_q;
	assign byte_value = byte_q;
	assign last       = last_q;

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= FR_STOP_B)
		else $error("frame index out of range");

	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> frame_kind == KIND_STOP)
		else $error("last frame is not a stop condition");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind != KIND_DATA |-> byte_value == 8'h00)
		else $error("start or stop frame carries a byte");

	a_set_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		set_valid && set_ready |=> out_valid && last)
		else $error("frame set released before its last frame");

	a_init_short: assert property (@(posedge clk) disable iff (!arst_n)
		set_valid && set_data.is_init |-> idx_q <= FR_STOP_A)
		else $error("init sequence ran past its stop frame");
`endif

endmodule

`default_nettype wire
